@@ hdl/prc_pkg.sv @@
// ---------------------------------------------------------------------------
// prc_pkg: shared types and constants of the polar/rectangular converter
// Widths, CORDIC constants, arctangent table and the lane structs that
// travel between the front end, the rotation cells and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

package prc_pkg;

  // operation codes
  localparam logic OP_TO_RECT  = 1'b0;
  localparam logic OP_TO_POLAR = 1'b1;

  localparam int ITERATIONS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // datapath widths: vector lanes carry 30 extra fraction bits, angles are Q30
  localparam int XW = 64;
  localparam int ZW = 34;
  localparam int MW = 33;
  localparam int GW = 31;
  localparam int QB = 30;

  localparam longint PI_Q30        = 64'sd3373259426;
  localparam longint HALF_PI_Q30   = 64'sd1686629713;
  localparam longint INV_GAIN_LIM  = 64'sd652032874;
  localparam longint INV_GAIN_CORR = INV_GAIN_LIM * 2 / 3;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  // gain compensation including the finite iteration correction
  function automatic longint prc_inv_gain(input int iter);
    return INV_GAIN_LIM + (INV_GAIN_CORR >>> (2 * iter));
  endfunction

  // pi rounded to frac fraction bits
  function automatic longint prc_pi_f(input int frac);
    return (PI_Q30 + (64'sd1 <<< (QB - frac - 1))) >>> (QB - frac);
  endfunction

  // operands after quadrant pre-rotation, ahead of the gain multiply
  typedef struct packed {
    logic                 vld;
    logic                 op;
    logic                 err;
    logic                 zero;
    logic signed [MW-1:0] mx;
    logic signed [MW-1:0] my;
    logic signed [ZW-1:0] z;
  } prc_oper_t;

  // one slot of the rotation chain
  typedef struct packed {
    logic                 vld;
    logic                 op;
    logic                 err;
    logic                 zero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } prc_lane_t;

endpackage

`default_nettype wire

@@ hdl/prc_front.sv @@
// ---------------------------------------------------------------------------
// prc_front: range check, quadrant pre-rotation and gain multiply
// Two register stages: operand selection, then the gain compensation
// multiply that loads the first rotation cell.
// ---------------------------------------------------------------------------
`default_nettype none

module prc_front
  import prc_pkg::*;
#(
  parameter int ITERATIONS = ITERATIONS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               take,
  input  wire logic               operation,
  input  wire logic signed [31:0] vec_x,
  input  wire logic signed [31:0] vec_y,
  input  wire logic signed [31:0] radius_in,
  input  wire logic signed [18:0] angle_in,
  output prc_lane_t               lane
);

  localparam int                   AngShift = QB - FRAC_BITS;
  localparam logic signed [ZW-1:0] PiF      = ZW'(prc_pi_f(FRAC_BITS));
  localparam logic signed [ZW-1:0] HalfPi   = ZW'(HALF_PI_Q30);
  localparam logic signed [GW-1:0] Gain     = GW'(prc_inv_gain(ITERATIONS));

  prc_oper_t oper_r, oper_nxt;
  prc_lane_t lane_r, lane_nxt;

  logic signed [ZW-1:0] ang_ext;
  logic signed [ZW-1:0] z_ang;
  logic signed [MW-1:0] r_ext;
  logic signed [MW-1:0] x_ext;
  logic signed [MW-1:0] y_ext;
  logic signed [MW-1:0] mx;
  logic signed [MW-1:0] my;

  always_comb begin
    ang_ext = ZW'(angle_in);
    z_ang   = ang_ext <<< AngShift;
    r_ext   = MW'(radius_in);
    x_ext   = MW'(vec_x);
    y_ext   = MW'(vec_y);

    oper_nxt.vld  = take;
    oper_nxt.op   = operation;
    oper_nxt.err  = (operation == OP_TO_RECT) && ((ang_ext > PiF) || (ang_ext < -PiF));
    oper_nxt.zero = (operation == OP_TO_POLAR) && (vec_x == 32'sd0) && (vec_y == 32'sd0);

    if (operation == OP_TO_RECT) begin
      // fold angles beyond a quarter turn onto the y axis
      if (z_ang > HalfPi) begin
        oper_nxt.mx = '0;
        oper_nxt.my = r_ext;
        oper_nxt.z  = z_ang - HalfPi;
      end else if (z_ang < -HalfPi) begin
        oper_nxt.mx = '0;
        oper_nxt.my = -r_ext;
        oper_nxt.z  = z_ang + HalfPi;
      end else begin
        oper_nxt.mx = r_ext;
        oper_nxt.my = '0;
        oper_nxt.z  = z_ang;
      end
    end else begin
      // left half plane: turn a quarter toward the positive x axis
      if (vec_x < 32'sd0) begin
        if (vec_y >= 32'sd0) begin
          oper_nxt.mx = y_ext;
          oper_nxt.my = -x_ext;
          oper_nxt.z  = HalfPi;
        end else begin
          oper_nxt.mx = -y_ext;
          oper_nxt.my = x_ext;
          oper_nxt.z  = -HalfPi;
        end
      end else begin
        oper_nxt.mx = x_ext;
        oper_nxt.my = y_ext;
        oper_nxt.z  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oper_r.vld <= 1'b0;
    end else begin
      oper_r <= oper_nxt;
    end
  end

  assign mx = oper_r.mx;
  assign my = oper_r.my;

  always_comb begin
    lane_nxt.vld  = oper_r.vld;
    lane_nxt.op   = oper_r.op;
    lane_nxt.err  = oper_r.err;
    lane_nxt.zero = oper_r.zero;
    lane_nxt.x    = XW'(mx) * XW'(Gain);
    lane_nxt.y    = XW'(my) * XW'(Gain);
    lane_nxt.z    = oper_r.z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.vld <= 1'b0;
    end else begin
      lane_r <= lane_nxt;
    end
  end

  assign lane = lane_r;

endmodule

`default_nettype wire

@@ hdl/prc_cell.sv @@
// ---------------------------------------------------------------------------
// prc_cell: one CORDIC micro-rotation
// Rotates the lane by +/- atan(2^-SHIFT), steered by the angle sign when
// rotating and by the y sign when vectoring, and registers the result.
// ---------------------------------------------------------------------------
`default_nettype none

module prc_cell
  import prc_pkg::*;
#(
  parameter int          SHIFT = 0,
  parameter logic [31:0] ATAN  = ATAN_TAB[0]
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire prc_lane_t lane_in,
  output prc_lane_t      lane_out
);

  localparam logic signed [ZW-1:0] AtanZ = ZW'(ATAN);

  prc_lane_t lane_r, lane_nxt;

  logic signed [XW-1:0] x;
  logic signed [XW-1:0] y;
  logic signed [ZW-1:0] z;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic                 ccw;

  assign x  = lane_in.x;
  assign y  = lane_in.y;
  assign z  = lane_in.z;
  assign xs = x >>> SHIFT;
  assign ys = y >>> SHIFT;

  // rotating drives z to zero, vectoring drives y to zero
  assign ccw = (lane_in.op == OP_TO_POLAR) ? y[XW-1] : ~z[ZW-1];

  always_comb begin
    lane_nxt = lane_in;
    if (ccw) begin
      lane_nxt.x = x - ys;
      lane_nxt.y = y + xs;
      lane_nxt.z = z - AtanZ;
    end else begin
      lane_nxt.x = x + ys;
      lane_nxt.y = y - xs;
      lane_nxt.z = z + AtanZ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.vld <= 1'b0;
    end else begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_out = lane_r;

endmodule

`default_nettype wire

@@ hdl/prc_back.sv @@
// ---------------------------------------------------------------------------
// prc_back: rounding, saturation and result selection
// Rounds the chain output back to the port formats, clamps it and zeroes
// the fields that the operation does not produce.
// ---------------------------------------------------------------------------
`default_nettype none

module prc_back
  import prc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire prc_lane_t          lane_in,
  output logic                    res_valid,
  output logic signed [31:0]      res_x,
  output logic signed [31:0]      res_y,
  output logic        [30:0]      res_radius,
  output logic signed [18:0]      res_angle,
  output logic                    range_error
);

  localparam int                   AngShift = QB - FRAC_BITS;
  localparam logic signed [ZW-1:0] PiF      = ZW'(prc_pi_f(FRAC_BITS));
  localparam logic signed [ZW-1:0] AngHalf  = ZW'(64'sd1 <<< (AngShift - 1));
  localparam logic signed [XW-1:0] RndHalf  = XW'(64'sd1 <<< (QB - 1));
  localparam logic signed [XW-1:0] SatMax   = XW'(64'sd2147483647);
  localparam logic signed [XW-1:0] SatMin   = XW'(-64'sd2147483648);

  logic signed [XW-1:0] x;
  logic signed [XW-1:0] y;
  logic signed [ZW-1:0] z;
  logic signed [XW-1:0] rx;
  logic signed [XW-1:0] ry;
  logic signed [ZW-1:0] rz;
  logic signed [31:0]   sat_x;
  logic signed [31:0]   sat_y;
  logic        [30:0]   rad;
  logic signed [18:0]   ang;

  logic               valid_r;
  logic signed [31:0] res_x_r, res_x_nxt;
  logic signed [31:0] res_y_r, res_y_nxt;
  logic        [30:0] res_radius_r, res_radius_nxt;
  logic signed [18:0] res_angle_r, res_angle_nxt;
  logic               range_error_r, range_error_nxt;

  assign x  = lane_in.x;
  assign y  = lane_in.y;
  assign z  = lane_in.z;
  assign rx = (x + RndHalf) >>> QB;
  assign ry = (y + RndHalf) >>> QB;
  assign rz = (z + AngHalf) >>> AngShift;

  always_comb begin
    if (rx > SatMax) begin
      sat_x = 32'(SatMax);
    end else if (rx < SatMin) begin
      sat_x = 32'(SatMin);
    end else begin
      sat_x = rx[31:0];
    end

    if (ry > SatMax) begin
      sat_y = 32'(SatMax);
    end else if (ry < SatMin) begin
      sat_y = 32'(SatMin);
    end else begin
      sat_y = ry[31:0];
    end

    if (rx[XW-1]) begin
      rad = '0;
    end else if (rx > SatMax) begin
      rad = 31'(SatMax);
    end else begin
      rad = rx[30:0];
    end

    // wider fraction formats keep only the low bits of the clamped angle
    if (rz > PiF) begin
      ang = PiF[18:0];
    end else if (rz < -PiF) begin
      ang = 19'(-PiF);
    end else begin
      ang = rz[18:0];
    end
  end

  always_comb begin
    res_x_nxt       = '0;
    res_y_nxt       = '0;
    res_radius_nxt  = '0;
    res_angle_nxt   = '0;
    range_error_nxt = 1'b0;
    if (lane_in.op == OP_TO_RECT) begin
      range_error_nxt = lane_in.err;
      if (!lane_in.err) begin
        res_x_nxt = sat_x;
        res_y_nxt = sat_y;
      end
    end else if (!lane_in.zero) begin
      res_radius_nxt = rad;
      res_angle_nxt  = ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= lane_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    res_x_r       <= res_x_nxt;
    res_y_r       <= res_y_nxt;
    res_radius_r  <= res_radius_nxt;
    res_angle_r   <= res_angle_nxt;
    range_error_r <= range_error_nxt & lane_in.vld;
  end

  assign res_valid   = valid_r;
  assign res_x       = res_x_r;
  assign res_y       = res_y_r;
  assign res_radius  = res_radius_r;
  assign res_angle   = res_angle_r;
  assign range_error = range_error_r;

endmodule

`default_nettype wire

@@ hdl/polar_rect_conversion_core.sv @@
// ---------------------------------------------------------------------------
// polar_rect_conversion_core: CORDIC polar/rectangular converter, Q16.16
// Fully pipelined converter between (radius, angle) and (x, y).
// ---------------------------------------------------------------------------
// The core takes one request in every clock cycle; busy is never raised.
// Each result appears on the out_ ports for a single cycle, marked by
// out_valid, after passing through two front stages (quadrant fold, gain
// multiply), one rotation cell per iteration and one rounding stage.
// Results leave in request order and cannot be held off, so the receiver
// must take every out_valid cycle.
`default_nettype none

module polar_rect_conversion_core
  import prc_pkg::*;
#(
  parameter int ITERATIONS = ITERATIONS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_operation,
  input  wire logic signed [31:0] in_vec_x,
  input  wire logic signed [31:0] in_vec_y,
  input  wire logic signed [31:0] in_radius_in,
  input  wire logic signed [18:0] in_angle_in,
  output logic                    out_valid,
  output logic signed [31:0]      out_res_x,
  output logic signed [31:0]      out_res_y,
  output logic        [30:0]      out_res_radius,
  output logic signed [18:0]      out_res_angle,
  output logic                    out_range_error
);

  localparam int Latency = ITERATIONS + 3;

  prc_lane_t lane [ITERATIONS+1];
  logic      take;

  assign busy = 1'b0;
  assign take = start && !busy;

  prc_front #(
    .ITERATIONS (ITERATIONS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .operation (in_operation),
    .vec_x     (in_vec_x),
    .vec_y     (in_vec_y),
    .radius_in (in_radius_in),
    .angle_in  (in_angle_in),
    .lane      (lane[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    prc_cell #(
      .SHIFT (i),
      .ATAN  (ATAN_TAB[i])
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .lane_in  (lane[i]),
      .lane_out (lane[i+1])
    );
  end

  prc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .lane_in     (lane[ITERATIONS]),
    .res_valid   (out_valid),
    .res_x       (out_res_x),
    .res_y       (out_res_y),
    .res_radius  (out_res_radius),
    .res_angle   (out_res_angle),
    .range_error (out_range_error)
  );

`ifndef SYNTHESIS
  // every taken request comes out exactly once, after the pipeline depth
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == ($past(take && rst_n, Latency) === 1'b1))
    else $error("result strobe does not match request timing");

  a_err_strobe : assert property (@(posedge clk) disable iff (!rst_n)
    out_range_error |-> out_valid)
    else $error("range error without a result");

  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |-> (out_res_x == 32'sd0 && out_res_y == 32'sd0))
    else $error("range error with nonzero coordinates");

  // a polar result carries no rectangular coordinates
  a_polar_clean : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_res_radius != 31'd0 || out_res_angle != 19'sd0))
      |-> (out_res_x == 32'sd0 && out_res_y == 32'sd0 && !out_range_error))
    else $error("mixed polar and rectangular result");
`endif

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench: polar/rectangular CORDIC converter
// Sends directed and random conversion requests in both directions, predicts
// each result with a bit-exact CORDIC model of its own and checks every
// out_valid strobe against the oldest pending prediction.
// ---------------------------------------------------------------------------

module testbench;

  import prc_pkg::*;

  localparam int     CORDIC_STEPS  = 16;
  localparam int     PIPE_LATENCY  = CORDIC_STEPS + 3;
  localparam int     CYCLE_LIMIT   = 200000;
  localparam longint GAIN_COMP_Q30 = 64'sd652032874 +
                                     ((64'sd652032874 * 2 / 3) >>> (2 * CORDIC_STEPS));
  localparam longint HALF_PI_Q30   = 64'sd1686629713;
  localparam longint PI_Q16        = (64'sd3373259426 + 64'sd8192) >>> 14;
  localparam longint HALF_PI_Q16   = HALF_PI_Q30 >>> 14;
  localparam longint S32_MAX       = 64'sd2147483647;
  localparam longint S32_MIN       = -64'sd2147483648;

  localparam longint ATAN_Q30 [CORDIC_STEPS] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
  };

  typedef struct packed {
    logic               op;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] radius;
    logic signed [18:0] angle;
  } conv_request_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [30:0] radius;
    logic signed [18:0] angle;
    logic               range_error;
  } conv_result_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_operation;
  logic signed [31:0] in_vec_x;
  logic signed [31:0] in_vec_y;
  logic signed [31:0] in_radius_in;
  logic signed [18:0] in_angle_in;
  logic               out_valid;
  logic signed [31:0] out_res_x;
  logic signed [31:0] out_res_y;
  logic        [30:0] out_res_radius;
  logic signed [18:0] out_res_angle;
  logic               out_range_error;

  conv_result_t pending_results[$];
  int           error_count = 0;
  int           cycle_count = 0;

  polar_rect_conversion_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_vec_x       (in_vec_x),
    .in_vec_y       (in_vec_y),
    .in_radius_in   (in_radius_in),
    .in_angle_in    (in_angle_in),
    .out_valid      (out_valid),
    .out_res_x      (out_res_x),
    .out_res_y      (out_res_y),
    .out_res_radius (out_res_radius),
    .out_res_angle  (out_res_angle),
    .out_range_error(out_range_error)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // bit-exact CORDIC conversion of one request
  function automatic conv_result_t predict_conversion(input conv_request_t rq);
    conv_result_t res;
    longint       x, y, z, t, rad, ang;
    int           i;
    res = '0;
    if (rq.op == OP_TO_RECT) begin
      z = rq.angle;
      if (z > PI_Q16 || z < -PI_Q16) begin
        res.range_error = 1'b1;
        return res;
      end
      z = z * 16384;
      x = longint'(rq.radius) * GAIN_COMP_Q30;
      y = 0;
      // fold the angle into the right half plane first
      if (z > HALF_PI_Q30) begin
        y = x; x = 0; z = z - HALF_PI_Q30;
      end else if (z < -HALF_PI_Q30) begin
        y = -x; x = 0; z = z + HALF_PI_Q30;
      end
      for (i = 0; i < CORDIC_STEPS; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i); y = y + (x >>> i); x = t; z = z - ATAN_Q30[i];
        end else begin
          t = x + (y >>> i); y = y - (x >>> i); x = t; z = z + ATAN_Q30[i];
        end
      end
      x = (x + (64'sd1 <<< 29)) >>> 30;
      y = (y + (64'sd1 <<< 29)) >>> 30;
      if (x > S32_MAX) x = S32_MAX;
      if (x < S32_MIN) x = S32_MIN;
      if (y > S32_MAX) y = S32_MAX;
      if (y < S32_MIN) y = S32_MIN;
      res.x = x[31:0];
      res.y = y[31:0];
      return res;
    end
    if (rq.vec_x == 0 && rq.vec_y == 0) return res;
    x = longint'(rq.vec_x) * GAIN_COMP_Q30;
    y = longint'(rq.vec_y) * GAIN_COMP_Q30;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = y; y = -x; x = t; z = HALF_PI_Q30;
      end else begin
        t = -y; y = x; x = t; z = -HALF_PI_Q30;
      end
    end
    for (i = 0; i < CORDIC_STEPS; i++) begin
      if (y >= 0) begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z = z + ATAN_Q30[i];
      end else begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z = z - ATAN_Q30[i];
      end
    end
    rad = (x + (64'sd1 <<< 29)) >>> 30;
    ang = (z + (64'sd1 <<< 13)) >>> 14;
    if (rad < 0) rad = 0;
    if (rad > S32_MAX) rad = S32_MAX;
    if (ang > PI_Q16) ang = PI_Q16;
    if (ang < -PI_Q16) ang = -PI_Q16;
    res.radius = rad[30:0];
    res.angle  = ang[18:0];
    return res;
  endfunction

  // full-width values shifted down by a random amount, so small ones show up too
  function automatic logic signed [31:0] random_coord();
    logic signed [31:0] v;
    v = $urandom;
    return v >>> $urandom_range(0, 31);
  endfunction

  function automatic logic signed [18:0] random_angle();
    int sel;
    int a;
    sel = $urandom_range(0, 99);
    if (sel < 80) begin
      a = int'($urandom_range(0, 2 * PI_Q16)) - int'(PI_Q16);
    end else if (sel < 90) begin
      case ($urandom_range(0, 3))
        0: a = int'(PI_Q16);
        1: a = -int'(PI_Q16);
        2: a = int'(HALF_PI_Q16);
        default: a = -int'(HALF_PI_Q16);
      endcase
      a = a + int'($urandom_range(0, 4)) - 2;
    end else if ($urandom_range(0, 1) == 1) begin
      a = int'($urandom_range(PI_Q16 + 1, 262143));
    end else begin
      a = -int'($urandom_range(PI_Q16 + 1, 262144));
    end
    return a[18:0];
  endfunction

  function automatic conv_request_t make_rect(input logic signed [31:0] r,
                                              input logic signed [18:0] a);
    conv_request_t rq;
    rq.op     = OP_TO_RECT;
    rq.vec_x  = $urandom;
    rq.vec_y  = $urandom;
    rq.radius = r;
    rq.angle  = a;
    return rq;
  endfunction

  function automatic conv_request_t make_polar(input logic signed [31:0] vx,
                                               input logic signed [31:0] vy);
    conv_request_t rq;
    rq.op     = OP_TO_POLAR;
    rq.vec_x  = vx;
    rq.vec_y  = vy;
    rq.radius = $urandom;
    rq.angle  = $urandom;
    return rq;
  endfunction

  function automatic conv_request_t random_request();
    conv_request_t rq;
    int            sel;
    rq = make_rect(random_coord(), random_angle());
    if ($urandom_range(0, 1) == 1) begin
      rq = make_polar(random_coord(), random_coord());
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        rq.vec_x = '0;
        rq.vec_y = '0;
      end else if (sel < 8) begin
        rq.vec_x = '0;
      end else if (sel < 13) begin
        rq.vec_y = '0;
      end
    end
    return rq;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input conv_request_t rq);
    start        = 1'b1;
    in_operation = rq.op;
    in_vec_x     = rq.vec_x;
    in_vec_y     = rq.vec_y;
    in_radius_in = rq.radius;
    in_angle_in  = rq.angle;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(predict_conversion(rq));
    @(negedge clk);
  endtask

  // no request for a while, with junk on the payload ports
  task automatic idle_cycles(input int n);
    start        = 1'b0;
    in_operation = $urandom;
    in_vec_x     = $urandom;
    in_vec_y     = $urandom;
    in_radius_in = $urandom;
    in_angle_in  = $urandom;
    repeat (n) @(negedge clk);
  endtask

  task automatic test_rect_special();
    send_request(make_rect(32'sd65536, 19'sd0));
    send_request(make_rect(32'sh7fffffff, 19'(PI_Q16)));
    send_request(make_rect(32'sh80000000, -19'(PI_Q16)));
    send_request(make_rect(32'sh80000000, 19'sd0));
    send_request(make_rect(32'sd0, 19'sd1000));
    send_request(make_rect(-32'sd1, 19'(HALF_PI_Q16)));
    send_request(make_rect(32'sd1, 19'(HALF_PI_Q16 + 1)));
    send_request(make_rect(32'sh7fffffff, -19'(HALF_PI_Q16)));
    send_request(make_rect(-32'sd123456, -19'(HALF_PI_Q16 + 1)));
    idle_cycles($urandom_range(1, 17));
  endtask

  task automatic test_angle_range();
    send_request(make_rect(32'sd65536, 19'(PI_Q16 + 1)));
    send_request(make_rect(32'sd65536, -19'(PI_Q16 + 1)));
    send_request(make_rect(32'sh7fffffff, 19'sh3ffff));
    send_request(make_rect(32'sh80000000, 19'sh40000));
    idle_cycles($urandom_range(1, 17));
  endtask

  task automatic test_polar_special();
    send_request(make_polar(32'sd0, 32'sd0));
    send_request(make_polar(32'sh7fffffff, 32'sh7fffffff));
    send_request(make_polar(32'sh80000000, 32'sh80000000));
    send_request(make_polar(32'sh80000000, 32'sd0));
    send_request(make_polar(-32'sd65536, -32'sd1));
    send_request(make_polar(32'sd0, 32'sd65536));
    send_request(make_polar(32'sd0, -32'sd65536));
    send_request(make_polar(32'sd1, 32'sd0));
    send_request(make_polar(-32'sd300000, 32'sd70000));
    send_request(make_polar(32'sh7fffffff, 32'sh80000000));
    idle_cycles($urandom_range(1, 17));
  endtask

  task automatic test_random_mix(input int count);
    int gap_pct;
    gap_pct = 0;
    for (int n = 0; n < count; n++) begin
      // vary the gap density in blocks, some blocks fully back to back
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 15;
          default: gap_pct = 50;
        endcase
      end
      send_request(random_request());
      if ($urandom_range(0, 99) < gap_pct) idle_cycles($urandom_range(1, 17));
    end
  endtask

  task automatic test_back_to_back(input int count);
    for (int n = 0; n < count; n++) send_request(random_request());
    start = 1'b0;
  endtask

  always @(posedge clk) begin
    conv_result_t exp_res;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result without a pending request");
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_res_x !== exp_res.x) begin
          $error("res_x: expected %0d, actual %0d", exp_res.x, out_res_x);
          error_count++;
        end
        if (out_res_y !== exp_res.y) begin
          $error("res_y: expected %0d, actual %0d", exp_res.y, out_res_y);
          error_count++;
        end
        if (out_res_radius !== exp_res.radius) begin
          $error("res_radius: expected %0d, actual %0d", exp_res.radius, out_res_radius);
          error_count++;
        end
        if (out_res_angle !== exp_res.angle) begin
          $error("res_angle: expected %0d, actual %0d", exp_res.angle, out_res_angle);
          error_count++;
        end
        if (out_range_error !== exp_res.range_error) begin
          $error("range_error: expected %0d, actual %0d", exp_res.range_error,
                 out_range_error);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = OP_TO_RECT;
    in_vec_x     = '0;
    in_vec_y     = '0;
    in_radius_in = '0;
    in_angle_in  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    idle_cycles(2);

    test_rect_special();
    test_angle_range();
    test_polar_special();
    test_random_mix(1520);
    test_back_to_back(400);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/prc_pkg.sv
hdl/prc_front.sv
hdl/prc_cell.sv
hdl/prc_back.sv
hdl/polar_rect_conversion_core.sv
tb/sv/testbench.sv
